// File: sv/iiee_pkg.sv
// Shared types, character codes and helper functions for the expression evaluator.
`default_nettype none

package iiee_pkg;

  localparam int WORD_BITS  = 32;
  localparam int VALUE_BITS = 32;
  localparam int CNT_BITS   = $clog2(WORD_BITS + 1);
  localparam int EXT_BITS   = (WORD_BITS > VALUE_BITS) ? WORD_BITS : VALUE_BITS;

  typedef logic [WORD_BITS-1:0] word_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] DIGIT_TEN = 4'd10;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] CL_DIGIT = 2'd0;
  localparam logic [1:0] CL_SPACE = 2'd1;
  localparam logic [1:0] CL_OP    = 2'd2;
  localparam logic [1:0] CL_BAD   = 2'd3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         div_zero;
    logic                         bad_char;
  } out_req_t;

  typedef struct packed {
    logic accept;
    logic load_plus;
    logic mul;
    logic div_start;
    logic div_take;
    logic apply;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_is_op;
    logic in_last;
    logic term_valid;
    logic mul_is_div;
    logic div_done;
    logic div_busy;
  } sts_t;

  function automatic logic [1:0] char_class(input logic [7:0] c);
    logic [1:0] cl;
    case (c) inside
      [CH_ZERO:CH_NINE]:                    cl = CL_DIGIT;
      CH_SPACE, [CH_TAB:CH_CR]:             cl = CL_SPACE;
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: cl = CL_OP;
      default:                              cl = CL_BAD;
    endcase
    return cl;
  endfunction

  function automatic logic [1:0] op_code(input logic [7:0] c);
    logic [1:0] op;
    case (c)
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      default:  op = OP_ADD;
    endcase
    return op;
  endfunction

  function automatic logic [VALUE_BITS-1:0] to_value(input word_t w);
    logic [EXT_BITS-1:0] ext;
    ext = EXT_BITS'(w);
    return ext[VALUE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/iiee_div.sv
// Iterative signed restoring divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module iiee_div
  import iiee_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire word_t dividend,
  input  wire word_t divisor,
  output logic       busy,
  output logic       done,
  output word_t      quotient,
  output logic       zero_div
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  word_t               quo_r, quo_nxt;
  word_t               rem_r, rem_nxt;
  word_t               mb_r, mb_nxt;
  logic                neg_r, neg_nxt;
  logic                zero_r, zero_nxt;

  logic [WORD_BITS:0]  shifted;
  logic [WORD_BITS:0]  trial;
  logic                sa, sb;

  always_comb begin
    sa       = dividend[WORD_BITS-1];
    sb       = divisor[WORD_BITS-1];
    shifted  = {rem_r, quo_r[WORD_BITS-1]};
    trial    = shifted - {1'b0, mb_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    mb_nxt   = mb_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    if (start) begin
      neg_nxt  = sa ^ sb;
      mb_nxt   = sb ? (~divisor + 1'b1) : divisor;
      quo_nxt  = sa ? (~dividend + 1'b1) : dividend;
      rem_nxt  = '0;
      zero_nxt = (divisor == '0);
      if (divisor == '0) begin
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        cnt_nxt  = CNT_BITS'(WORD_BITS);
      end
    end else if (busy_r) begin
      if (!trial[WORD_BITS]) begin
        rem_nxt = trial[WORD_BITS-1:0];
        quo_nxt = {quo_r[WORD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[WORD_BITS-1:0];
        quo_nxt = {quo_r[WORD_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    mb_r   <= mb_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign zero_div = zero_r;
  assign quotient = zero_r ? '0 : (neg_r ? (~quo_r + 1'b1) : quo_r);

endmodule

`default_nettype wire

// File: sv/iiee_dp.sv
// Datapath: number assembly, pending sum and term, multiplier, divider and result register.
`default_nettype none

module iiee_dp
  import iiee_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_req_t  in_req,
  input  wire cmd_t     cmd,
  output sts_t          sts,
  output out_req_t      out_req
);

  word_t      sum_r, sum_nxt;
  logic       sum_valid_r, sum_valid_nxt;
  logic       minus_r, minus_nxt;
  word_t      term_r, term_nxt;
  logic       term_valid_r, term_valid_nxt;
  logic       is_div_r, is_div_nxt;
  word_t      cur_r, cur_nxt;
  logic       err_div_r, err_div_nxt;
  logic       err_bad_r, err_bad_nxt;
  logic [1:0] op_r, op_nxt;
  word_t      v_r, v_nxt;
  out_req_t   out_r, out_nxt;

  logic [1:0] in_class;
  word_t      digit_val;
  word_t      quotient;
  logic       div_busy, div_done, div_zero;

  iiee_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (term_r),
    .divisor  (v_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient),
    .zero_div (div_zero)
  );

  always_comb begin
    in_class  = char_class(in_req.char_code);
    digit_val = WORD_BITS'(in_req.char_code - CH_ZERO);

    sum_nxt        = sum_r;
    sum_valid_nxt  = sum_valid_r;
    minus_nxt      = minus_r;
    term_nxt       = term_r;
    term_valid_nxt = term_valid_r;
    is_div_nxt     = is_div_r;
    cur_nxt        = cur_r;
    err_div_nxt    = err_div_r;
    err_bad_nxt    = err_bad_r;
    op_nxt         = op_r;
    v_nxt          = v_r;
    out_nxt        = out_r;

    if (cmd.accept) begin
      case (in_class)
        CL_DIGIT: cur_nxt = WORD_BITS'(cur_r * DIGIT_TEN) + digit_val;
        CL_OP: begin
          op_nxt = op_code(in_req.char_code);
          v_nxt  = cur_r;
        end
        CL_BAD:   err_bad_nxt = 1'b1;
        default: ;
      endcase
    end

    if (cmd.load_plus) begin
      op_nxt = OP_ADD;
      v_nxt  = cur_r;
    end

    if (cmd.mul) begin
      v_nxt = WORD_BITS'(term_r * v_r);
    end

    if (cmd.div_take) begin
      v_nxt       = quotient;
      err_div_nxt = err_div_r | div_zero;
    end

    if (cmd.apply) begin
      term_valid_nxt = 1'b0;
      cur_nxt        = '0;
      if ((op_r == OP_MUL) || (op_r == OP_DIV)) begin
        term_nxt       = v_r;
        term_valid_nxt = 1'b1;
        is_div_nxt     = (op_r == OP_DIV);
      end else begin
        if (!sum_valid_r) begin
          sum_nxt       = v_r;
          sum_valid_nxt = 1'b1;
        end else begin
          sum_nxt = minus_r ? (sum_r - v_r) : (sum_r + v_r);
        end
        minus_nxt = (op_r == OP_SUB);
      end
    end

    // Capture the result, then drop all expression state for the next one
    if (cmd.emit) begin
      out_nxt.value    = to_value(sum_r);
      out_nxt.div_zero = err_div_r;
      out_nxt.bad_char = err_bad_r;
      sum_nxt          = '0;
      sum_valid_nxt    = 1'b0;
      minus_nxt        = 1'b0;
      term_nxt         = '0;
      term_valid_nxt   = 1'b0;
      is_div_nxt       = 1'b0;
      cur_nxt          = '0;
      err_div_nxt      = 1'b0;
      err_bad_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= '0;
      sum_valid_r  <= 1'b0;
      minus_r      <= 1'b0;
      term_r       <= '0;
      term_valid_r <= 1'b0;
      is_div_r     <= 1'b0;
      cur_r        <= '0;
      err_div_r    <= 1'b0;
      err_bad_r    <= 1'b0;
    end else begin
      sum_r        <= sum_nxt;
      sum_valid_r  <= sum_valid_nxt;
      minus_r      <= minus_nxt;
      term_r       <= term_nxt;
      term_valid_r <= term_valid_nxt;
      is_div_r     <= is_div_nxt;
      cur_r        <= cur_nxt;
      err_div_r    <= err_div_nxt;
      err_bad_r    <= err_bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    v_r   <= v_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    sts.in_is_op   = (in_class == CL_OP);
    sts.in_last    = in_req.last;
    sts.term_valid = term_valid_r;
    sts.mul_is_div = is_div_r;
    sts.div_done   = div_done;
    sts.div_busy   = div_busy;
  end

  assign out_req = out_r;

endmodule

`default_nettype wire

// File: sv/iiee_ctrl.sv
// Controller state machine: sequences operator evaluation, the closing '+' and result hand-off.
`default_nettype none

module iiee_ctrl
  import iiee_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PLUS  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       last_r, last_nxt;
  logic       final_r, final_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    last_nxt  = last_r;
    final_nxt = final_r;
    slot_free = !out_valid_r || !out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          last_nxt   = sts.in_last;
          final_nxt  = 1'b0;
          if (sts.in_is_op) begin
            state_nxt = S_EVAL;
          end else if (sts.in_last) begin
            state_nxt = S_PLUS;
          end
        end
      end
      S_PLUS: begin
        cmd.load_plus = 1'b1;
        final_nxt     = 1'b1;
        state_nxt     = S_EVAL;
      end
      S_EVAL: begin
        if (!sts.term_valid) begin
          cmd.apply = 1'b1;
          state_nxt = final_r ? S_EMIT : (last_r ? S_PLUS : S_IDLE);
        end else if (sts.mul_is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_APPLY;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = final_r ? S_EMIT : (last_r ? S_PLUS : S_IDLE);
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          last_nxt  = 1'b0;
          final_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: sv/infix_int_expression_evaluator_core.sv
// Top level of the infix integer expression evaluator: controller, datapath and checks.
`default_nettype none

// Evaluates an infix expression of non-negative decimal integers with + - * / and
// whitespace, fed one ASCII character per input request; the request flagged last
// closes the expression with an implicit '+', and one result request then carries
// the 32-bit wrapped value plus sticky divide-by-zero and bad-character flags, after
// which all expression state clears. '*' and '/' bind tighter than '+' and '-';
// division truncates toward zero, and a quotient by zero is taken as 0. A digit,
// whitespace or ignored character is accepted with no further evaluation step. An
// operator that closes a multiplication adds a pass through the single 32x32
// multiplier, which is registered; one that closes a division waits on the restoring
// divider, which retires one quotient bit per cycle and skips the iteration on a zero
// divisor. The last character adds the closing '+' pass and a load of the result
// register. The result register lets the next expression start while a finished
// result is still stalled downstream.
module infix_int_expression_evaluator_core
  import iiee_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_req_t  in_req,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_req_t      out_req
);

  cmd_t cmd;
  sts_t sts;

  // Sequence each request through evaluation steps
  iiee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold operands, pending sum and term, and the result register
  iiee_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .sts     (sts),
    .out_req (out_req)
  );

  // Divider running means no new request may be taken
  a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_busy |-> in_stall)
    else $error("input accepted while divider busy");

  // Never restart the divider mid-division
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider restarted while busy");

  // Never overwrite a result still stalled downstream
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

  // A captured result is offered in the following cycle
  a_emit_offers: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("captured result not offered");

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps
// Testbench for the expression evaluator: directed and random character streams checked against a predictor.

module tb;
  import iiee_pkg::*;

  typedef enum logic [1:0] {K_DIGIT, K_SPACE, K_OPER, K_OTHER} char_kind_t;

  // One directed request; the typed result applies only where typed_res is set.
  typedef struct packed {
    logic [7:0]  code;
    logic        last;
    logic        typed_res;
    logic [31:0] value;
    logic        dz;
    logic        bc;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_stall;
  out_req_t out_req;

  // Predictor state: pending sum, pending product or quotient, number being read.
  word_t sum_val, term_val, cur_num;
  logic  sum_open, sum_neg, term_open, term_div, div_seen, bad_seen;

  out_req_t    results_due[$];
  out_req_t    want_res;
  logic [7:0]  expr_chars[$];
  dir_row_t    dir_rows[0:23];
  int unsigned counted;
  int unsigned mismatch_count;
  int unsigned burst_left;
  int unsigned hold_cycles;
  bit          hold_go;
  bit          hold_done;
  bit          drained_once;

  infix_int_expression_evaluator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_req  (out_req)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Ends the run should the block hang.
  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic char_kind_t char_kind(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return K_DIGIT;
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return K_SPACE;
    if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) return K_OPER;
    return K_OTHER;
  endfunction

  // Signed division truncating toward zero; the caller deals with a zero divisor.
  function automatic word_t trunc_quot(input word_t a, input word_t b);
    word_t ma, mb, q;
    ma = a[WORD_BITS-1] ? -a : a;
    mb = b[WORD_BITS-1] ? -b : b;
    q  = ma / mb;
    return (a[WORD_BITS-1] ^ b[WORD_BITS-1]) ? -q : q;
  endfunction

  task automatic clear_calc();
    sum_val   = '0;
    term_val  = '0;
    cur_num   = '0;
    sum_open  = 1'b0;
    sum_neg   = 1'b0;
    term_open = 1'b0;
    term_div  = 1'b0;
    div_seen  = 1'b0;
    bad_seen  = 1'b0;
  endtask

  // Fold the number just read into the pending term and sum, then open the next operator.
  task automatic close_operand(input logic [7:0] c);
    word_t v;
    v = cur_num;
    if (term_open) begin
      if (!term_div) begin
        v = term_val * v;
      end else if (v == '0) begin
        div_seen = 1'b1;
      end else begin
        v = trunc_quot(term_val, v);
      end
      term_open = 1'b0;
    end
    if (c == CH_STAR || c == CH_SLASH) begin
      term_val  = v;
      term_open = 1'b1;
      term_div  = (c == CH_SLASH);
    end else if (!sum_open) begin
      sum_val  = v;
      sum_open = 1'b1;
      sum_neg  = (c == CH_MINUS);
    end else begin
      sum_val = sum_neg ? sum_val - v : sum_val + v;
      sum_neg = (c == CH_MINUS);
    end
    cur_num = '0;
  endtask

  task automatic step_calc(input in_req_t r, output logic emitted, output out_req_t res);
    emitted = 1'b0;
    res     = '0;
    case (char_kind(r.char_code))
      K_DIGIT: cur_num = cur_num * word_t'(DIGIT_TEN) + word_t'(r.char_code - CH_ZERO);
      K_SPACE: ;
      K_OPER:  close_operand(r.char_code);
      default: bad_seen = 1'b1;
    endcase
    if (r.last) begin
      // The last character is taken first, then the implied closing plus.
      close_operand(CH_PLUS);
      res.value    = sum_val;
      res.div_zero = div_seen;
      res.bad_char = bad_seen;
      emitted      = 1'b1;
      clear_calc();
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_space();
    if ($urandom_range(0, 5) == 0) return CH_SPACE;
    return CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] pick_bad();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (char_kind(c) != K_OTHER);
    return c;
  endfunction

  // Append one character to the expression being built.
  task automatic queue_char(input logic [7:0] c);
    expr_chars.insert(expr_chars.size(), c);
  endtask

  // Build one expression: mostly well formed with random operands, some noise.
  task automatic build_expr();
    int unsigned     terms;
    longint unsigned num;
    string           txt;
    expr_chars.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) queue_char(8'($urandom_range(0, 255)));
      return;
    end
    terms = $urandom_range(1, 6);
    if ($urandom_range(0, 9) == 0) queue_char(pick_op());
    for (int t = 0; t < terms; t++) begin
      if (t != 0) begin
        queue_char(pick_op());
        if ($urandom_range(0, 29) == 0) queue_char(pick_op());
      end
      if ($urandom_range(0, 39) == 0) begin
        // most negative value over a literal that wraps to minus one
        txt = "2147483648/4294967295";
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: num = $urandom_range(0, 9);
          4, 5:       num = $urandom_range(0, 999);
          6:          num = $urandom;
          7:          num = {$urandom, $urandom};
          8: begin
            case ($urandom_range(0, 3))
              0:       num = 64'd1;
              1:       num = 64'd2147483648;
              2:       num = 64'd4294967295;
              default: num = 64'd2147483647;
            endcase
          end
          default:    num = 64'd0;
        endcase
        txt = $sformatf("%0d", num);
      end
      for (int k = 0; k < txt.len(); k++) begin
        queue_char(txt[k]);
        if ($urandom_range(0, 19) == 0) queue_char(pick_space());
        if ($urandom_range(0, 59) == 0) queue_char(pick_bad());
      end
    end
    if ($urandom_range(0, 19) == 0) queue_char(pick_op());
  endtask

  // Offer one request from a falling edge, hold it until taken, predict, return at the
  // next falling edge with nothing yet driven in that step.
  task automatic push_char(input logic [7:0] code, input logic fin, input logic use_typed,
                           input out_req_t typed_res);
    in_req_t    r;
    logic       emitted;
    out_req_t   res;
    char_kind_t kind;
    r.char_code = code;
    r.last      = fin;
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    step_calc(r, emitted, res);
    if (emitted) results_due.insert(results_due.size(), use_typed ? typed_res : res);
    kind = char_kind(code);
    if (fin || kind == K_DIGIT || kind == K_OPER) counted++;
    @(negedge clk);
  endtask

  // Bursts of random length, random gaps; no gaps while the receiver holds off.
  task automatic pace_sender();
    if (burst_left != 0) burst_left--;
    if (burst_left == 0 && hold_cycles == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  endtask

  // Drop valid and wait until every result has come, checking only after a falling edge.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due.size() != 0);
  endtask

  // Receiver: stall on a pattern of its own, switching mode now and then, and hold off
  // once for a long stretch so that the block fills up and stalls its input.
  initial begin
    int unsigned mode, span, phase;
    out_stall = 1'b0;
    span      = 0;
    phase     = 0;
    mode      = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 300);
      end
      span--;
      phase++;
      if (hold_go && !hold_done) begin
        hold_done   = 1'b1;
        hold_cycles = 800;
      end
      if (hold_cycles != 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((phase % 5) < 2);
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest one due.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        note_mismatch("result with none due", out_req.value, 32'd0);
      end else begin
        want_res = results_due.pop_front();
        if (out_req.value !== want_res.value)
          note_mismatch("value", out_req.value, want_res.value);
        if (out_req.div_zero !== want_res.div_zero)
          note_mismatch("div_zero", 32'(out_req.div_zero), 32'(want_res.div_zero));
        if (out_req.bad_char !== want_res.bad_char)
          note_mismatch("bad_char", 32'(out_req.bad_char), 32'(want_res.bad_char));
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req         = '0;
    counted        = 0;
    mismatch_count = 0;
    burst_left     = 0;
    hold_cycles    = 0;
    hold_go        = 1'b0;
    hold_done      = 1'b0;
    drained_once   = 1'b0;
    clear_calc();

    // code, last, typed, value, div_zero, bad_char
    dir_rows = '{
      '{CH_SPACE,            1'b1, 1'b1, 32'd0,     1'b0, 1'b0},  // empty expression
      '{8'h00,               1'b1, 1'b1, 32'd0,     1'b0, 1'b1},  // lowest byte, ignored
      '{8'hFF,               1'b1, 1'b1, 32'd0,     1'b0, 1'b1},  // highest byte, ignored
      '{CH_ZERO + 8'd9,      1'b1, 1'b1, 32'd9,     1'b0, 1'b0},
      '{CH_ZERO + 8'd2,      1'b0, 1'b0, 32'd0,     1'b0, 1'b0},  // precedence
      '{CH_PLUS,             1'b0, 1'b0, 32'd0,     1'b0, 1'b0},
      '{CH_ZERO + 8'd3,      1'b0, 1'b0, 32'd0,     1'b0, 1'b0},
      '{CH_STAR,             1'b0, 1'b0, 32'd0,     1'b0, 1'b0},
      '{CH_ZERO + 8'd4,      1'b1, 1'b0, 32'd0,     1'b0, 1'b0},
      '{CH_MINUS,            1'b0, 1'b0, 32'd0,     1'b0, 1'b0},  // leading minus negates
      '{CH_ZERO + 8'd5,      1'b1, 1'b1, -32'sd5,   1'b0, 1'b0},
      '{CH_ZERO + 8'd8,      1'b0, 1'b0, 32'd0,     1'b0, 1'b0},  // divide by zero
      '{CH_SLASH,            1'b0, 1'b0, 32'd0,     1'b0, 1'b0},
      '{CH_ZERO,             1'b1, 1'b1, 32'd0,     1'b1, 1'b0},
      '{CH_ZERO + 8'd3,      1'b0, 1'b0, 32'd0,     1'b0, 1'b0},  // trailing operator as last
      '{CH_PLUS,             1'b1, 1'b1, 32'd3,     1'b0, 1'b0},
      '{CH_ZERO + 8'd7,      1'b0, 1'b0, 32'd0,     1'b0, 1'b0},  // truncating division
      '{CH_MINUS,            1'b0, 1'b0, 32'd0,     1'b0, 1'b0},
      '{CH_ZERO + 8'd9,      1'b0, 1'b0, 32'd0,     1'b0, 1'b0},
      '{CH_SLASH,            1'b0, 1'b0, 32'd0,     1'b0, 1'b0},
      '{CH_ZERO + 8'd2,      1'b1, 1'b0, 32'd0,     1'b0, 1'b0},
      '{CH_TAB,              1'b0, 1'b0, 32'd0,     1'b0, 1'b0},  // whitespace skipped
      '{CH_ZERO + 8'd6,      1'b0, 1'b0, 32'd0,     1'b0, 1'b0},
      '{CH_CR,               1'b1, 1'b1, 32'd6,     1'b0, 1'b0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      push_char(dir_rows[i].code, dir_rows[i].last, dir_rows[i].typed_res,
                {dir_rows[i].value, dir_rows[i].dz, dir_rows[i].bc});
      pace_sender();
    end
    drain_results();

    // Start the long hold-off, then random expressions.
    hold_go = 1'b1;
    while (counted < 1600) begin
      build_expr();
      foreach (expr_chars[k]) begin
        push_char(expr_chars[k], k == expr_chars.size() - 1, 1'b0, '0);
        pace_sender();
      end
      if (!drained_once && counted >= 800) begin
        drained_once = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
